### rtl/i2cee_pkg.sv
// Shared types and codes for the EEPROM random-access I2C master.
// Used by i2cee_cfg, i2cee_core and the top level; no dependencies.
package i2cee_pkg;

  // Request kinds carried in the input tuser field
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Byte slots of a transaction
  localparam logic [1:0] SLOT_DEV_W = 2'd0;
  localparam logic [1:0] SLOT_MEM   = 2'd1;
  localparam logic [1:0] SLOT_DATA  = 2'd2;
  localparam logic [1:0] SLOT_DEV_R = 2'd3;

  localparam logic [2:0] BIT_TOP = 3'd7;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_ACK_WAIT    = 1'b0;
  localparam logic REG_WRITE_CYCLE = 1'b1;
  localparam logic [19:0] WRITE_CYCLE_RESET = 20'd10000;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START,
    PH_TX_LOW,
    PH_TX_HIGH,
    PH_ACK_LOW,
    PH_ACK_HIGH,
    PH_RS_LOW,
    PH_RS_HIGH,
    PH_RS_START,
    PH_RX_LOW,
    PH_RX_HIGH,
    PH_NACK_LOW,
    PH_NACK_HIGH,
    PH_STOP_LOW,
    PH_STOP_HIGH,
    PH_STOP_REL,
    PH_WAIT
  } phase_t;

  typedef struct packed {
    logic [15:0] ack_wait_limit;
    logic [19:0] write_cycle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] dev_addr;
    logic [7:0] mem_addr;
    logic [7:0] wr_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_missing;
  } result_t;

endpackage

### rtl/i2c_eeprom_random_access_master_top.sv
// Top level of the EEPROM random-access I2C master: stream ports, input and
// result registers around the phase sequencer. Depends on i2cee_pkg,
// i2cee_cfg and i2cee_core.
//
//  channel | ports                        | one transfer
//  --------+------------------------------+------------------------------------
//  in      | in_tvalid/tready/tdata/tuser | one bus phase or a command
//  out     | out_tvalid/tready/tdata      | line levels and status of a phase
//  cfg     | cfg_psel ... cfg_pready      | one register write or read
//
// Each item passes through the input register and the sequencer step logic into
// the result register, one item per clock sustained while out_tready keeps the
// result register draining. The input side takes a new transfer whenever the
// input register is empty or moves on in the same cycle, so a result left
// waiting on out_tready stalls at most one queued item. Synchronous active-low
// reset empties both registers and returns the bus to idle (SCL high, SDA
// released); configuration returns to a zero ack limit and 10000 wait ticks.
module i2c_eeprom_random_access_master_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [6:0] dev_addr, [14:7] mem_addr, [22:15] wr_data, [23] sda_in
  input  logic [23:0]                      in_tdata,
  // [1:0] req_type
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] done_res,
  // [11:4] read_byte, [12] ack_missing, [15:13] zero
  output logic [15:0]                      out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [i2cee_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import i2cee_pkg::*;

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_v_r;
  result_t step_res;
  result_t out_res_r;
  logic    out_v_r;
  logic    advance;

  i2cee_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Step the sequencer when an item is held and the result slot frees up
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  // Unpack the transfer into the item register
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.req_type <= in_tuser;
      in_item_r.dev_addr <= in_tdata[6:0];
      in_item_r.mem_addr <= in_tdata[14:7];
      in_item_r.wr_data  <= in_tdata[22:15];
      in_item_r.sda_in   <= in_tdata[23];
    end
  end

  i2cee_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res_r <= step_res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'd0, out_res_r.ack_missing, out_res_r.read_byte,
                       out_res_r.done_res, out_res_r.busy_res,
                       out_res_r.sda_pull_low, out_res_r.scl_level};

endmodule

### rtl/i2cee_cfg.sv
// APB-style configuration registers: ack wait limit and write-cycle length.
// Depends on i2cee_pkg.
module i2cee_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2cee_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output i2cee_pkg::cfg_t                   cfg
);
  import i2cee_pkg::*;

  logic [15:0] ack_wait_r;
  logic [19:0] write_cycle_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_wait_r    <= '0;
      write_cycle_r <= WRITE_CYCLE_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ACK_WAIT:    ack_wait_r    <= pwdata[15:0];
        REG_WRITE_CYCLE: write_cycle_r <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ACK_WAIT:    prdata = {16'd0, ack_wait_r};
      REG_WRITE_CYCLE: prdata = {12'd0, write_cycle_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.ack_wait_limit    = ack_wait_r;
  assign cfg.write_cycle_ticks = write_cycle_r;

endmodule

### rtl/i2cee_core.sv
// Bus-phase sequencer: state registers and one-phase step logic per item.
// Depends on i2cee_pkg.
module i2cee_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  i2cee_pkg::item_t   item,
  input  i2cee_pkg::cfg_t    cfg,
  output i2cee_pkg::result_t res
);
  import i2cee_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  rcvd_r, rcvd_nxt;
  logic        is_read_r, is_read_nxt;
  logic [6:0]  dev_r, dev_nxt;
  logic [7:0]  mem_r, mem_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [19:0] wait_r, wait_nxt;
  logic        fail_r, fail_nxt;

  logic        scl, pull, done;
  logic        tx_bit;
  logic [19:0] wait_inc;
  logic [19:0] wait_dec;
  logic [7:0]  rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      slot_r    <= SLOT_DEV_W;
      bit_cnt_r <= BIT_TOP;
      shift_r   <= '0;
      rcvd_r    <= '0;
      is_read_r <= 1'b0;
      dev_r     <= '0;
      mem_r     <= '0;
      data_r    <= '0;
      wait_r    <= '0;
      fail_r    <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      slot_r    <= slot_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      rcvd_r    <= rcvd_nxt;
      is_read_r <= is_read_nxt;
      dev_r     <= dev_nxt;
      mem_r     <= mem_nxt;
      data_r    <= data_nxt;
      wait_r    <= wait_nxt;
      fail_r    <= fail_nxt;
    end
  end

  assign tx_bit   = shift_r[bit_cnt_r];
  assign wait_inc = wait_r + 20'd1;
  assign wait_dec = (wait_r != 20'd0) ? wait_r - 20'd1 : wait_r;

  always_comb begin
    rx_byte = shift_r;
    rx_byte[bit_cnt_r] = item.sda_in;
  end

  always_comb begin
    phase_nxt   = phase_r;
    slot_nxt    = slot_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    rcvd_nxt    = rcvd_r;
    is_read_nxt = is_read_r;
    dev_nxt     = dev_r;
    mem_nxt     = mem_r;
    data_nxt    = data_r;
    wait_nxt    = wait_r;
    fail_nxt    = fail_r;
    scl         = 1'b1;
    pull        = 1'b0;
    done        = 1'b0;

    case (phase_r)
      PH_IDLE: begin
        if (item.req_type == REQ_WRITE || item.req_type == REQ_READ) begin
          dev_nxt     = item.dev_addr;
          mem_nxt     = item.mem_addr;
          data_nxt    = item.wr_data;
          is_read_nxt = (item.req_type == REQ_READ);
          fail_nxt    = 1'b0;
          wait_nxt    = '0;
          phase_nxt   = PH_START;
        end
      end
      PH_START: begin
        pull        = 1'b1;
        slot_nxt    = SLOT_DEV_W;
        shift_nxt   = {dev_r, 1'b0};
        bit_cnt_nxt = BIT_TOP;
        wait_nxt    = '0;
        phase_nxt   = PH_TX_LOW;
      end
      PH_TX_LOW: begin
        scl       = 1'b0;
        pull      = ~tx_bit;
        phase_nxt = PH_TX_HIGH;
      end
      PH_TX_HIGH: begin
        pull = ~tx_bit;
        if (bit_cnt_r == 3'd0) begin
          phase_nxt = PH_ACK_LOW;
        end else begin
          bit_cnt_nxt = bit_cnt_r - 3'd1;
          phase_nxt   = PH_TX_LOW;
        end
      end
      PH_ACK_LOW: begin
        scl       = 1'b0;
        phase_nxt = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        if (!item.sda_in) begin
          wait_nxt = '0;
          case (slot_r)
            SLOT_DEV_W: begin
              slot_nxt    = SLOT_MEM;
              shift_nxt   = mem_r;
              bit_cnt_nxt = BIT_TOP;
              phase_nxt   = PH_TX_LOW;
            end
            SLOT_MEM: begin
              if (is_read_r) begin
                phase_nxt = PH_RS_LOW;
              end else begin
                slot_nxt    = SLOT_DATA;
                shift_nxt   = data_r;
                bit_cnt_nxt = BIT_TOP;
                phase_nxt   = PH_TX_LOW;
              end
            end
            SLOT_DATA: phase_nxt = PH_STOP_LOW;
            default: begin
              bit_cnt_nxt = BIT_TOP;
              shift_nxt   = '0;
              phase_nxt   = PH_RX_LOW;
            end
          endcase
        end else if (cfg.ack_wait_limit != 16'd0) begin
          // Count ticks with SDA still high; give up at the limit
          if (wait_inc >= {4'd0, cfg.ack_wait_limit}) begin
            fail_nxt  = 1'b1;
            wait_nxt  = '0;
            phase_nxt = PH_STOP_LOW;
          end else begin
            wait_nxt = wait_inc;
          end
        end
      end
      PH_RS_LOW: begin
        scl       = 1'b0;
        phase_nxt = PH_RS_HIGH;
      end
      PH_RS_HIGH: phase_nxt = PH_RS_START;
      PH_RS_START: begin
        pull        = 1'b1;
        slot_nxt    = SLOT_DEV_R;
        shift_nxt   = {dev_r, 1'b1};
        bit_cnt_nxt = BIT_TOP;
        wait_nxt    = '0;
        phase_nxt   = PH_TX_LOW;
      end
      PH_RX_LOW: begin
        scl       = 1'b0;
        phase_nxt = PH_RX_HIGH;
      end
      PH_RX_HIGH: begin
        shift_nxt = rx_byte;
        if (bit_cnt_r == 3'd0) begin
          rcvd_nxt  = rx_byte;
          phase_nxt = PH_NACK_LOW;
        end else begin
          bit_cnt_nxt = bit_cnt_r - 3'd1;
          phase_nxt   = PH_RX_LOW;
        end
      end
      PH_NACK_LOW: begin
        scl       = 1'b0;
        phase_nxt = PH_NACK_HIGH;
      end
      PH_NACK_HIGH: phase_nxt = PH_STOP_LOW;
      PH_STOP_LOW: begin
        scl       = 1'b0;
        pull      = 1'b1;
        phase_nxt = PH_STOP_HIGH;
      end
      PH_STOP_HIGH: begin
        pull      = 1'b1;
        phase_nxt = PH_STOP_REL;
      end
      PH_STOP_REL: begin
        done = 1'b1;
        if (!is_read_r && !fail_r && cfg.write_cycle_ticks != 20'd0) begin
          wait_nxt  = cfg.write_cycle_ticks;
          phase_nxt = PH_WAIT;
        end else begin
          wait_nxt  = '0;
          phase_nxt = PH_IDLE;
        end
      end
      PH_WAIT: begin
        wait_nxt = wait_dec;
        if (wait_dec == 20'd0) phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  assign res.scl_level    = scl;
  assign res.sda_pull_low = pull;
  assign res.busy_res     = (phase_nxt != PH_IDLE);
  assign res.done_res     = done;
  assign res.read_byte    = rcvd_nxt;
  assign res.ack_missing  = fail_nxt;

endmodule
